/* rtl/ipf_pkg.sv */
// Shared types, constants and helper functions for the IPv4 rule filter.
`default_nettype none

package ipf_pkg;

    // Frame length limit and the width of the byte offset that counts up to it.
    localparam int MAX_FRAME_LEN = 16384;
    localparam int OFF_W         = $clog2(MAX_FRAME_LEN + 1);

    // Byte offsets of the captured header fields.
    localparam int OFF_ETYPE_HI = 12;
    localparam int OFF_ETYPE_LO = 13;
    localparam int OFF_IHL      = 14;
    localparam int OFF_PROTO    = 23;
    localparam int OFF_SRC0     = 26;
    localparam int OFF_SRC1     = 27;
    localparam int OFF_SRC2     = 28;
    localparam int OFF_SRC3     = 29;
    localparam int L4_BASE      = 14;
    localparam int MIN_IP_LEN   = 34;
    localparam int TCP_HDR_LEN  = 20;
    localparam int UDP_HDR_LEN  = 8;

    // Protocol and port numbers.
    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [15:0] PORT_SSH   = 16'd22;
    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_IPERF = 16'd5201;
    localparam logic [15:0] PORT_DNS   = 16'd53;
    localparam logic [15:0] PORT_UDPT  = 16'd5001;

    // Configuration register indexes and reset values.
    localparam int          CFG_IDX_W      = 2;
    localparam int          CFG_DATA_W     = 32;
    localparam logic [1:0]  CFG_BASTION    = 2'd0;
    localparam logic [1:0]  CFG_BLOCKED    = 2'd1;
    localparam logic [1:0]  CFG_ADMIN      = 2'd2;
    localparam logic [31:0] BASTION_RESET  = 32'h0A0832B4;
    localparam logic [23:0] BLOCKED_RESET  = 24'hC0A864;
    localparam logic [7:0]  ADMIN_RESET    = 8'h0A;

    // Rule numbers reported in rule_hit.
    localparam logic [2:0] RULE_NON_IP  = 3'd0;
    localparam logic [2:0] RULE_BASTION = 3'd1;
    localparam logic [2:0] RULE_SUBNET  = 3'd2;
    localparam logic [2:0] RULE_ADMIN   = 3'd3;
    localparam logic [2:0] RULE_TCP     = 3'd4;
    localparam logic [2:0] RULE_UDP     = 3'd5;
    localparam logic [2:0] RULE_ICMP    = 3'd6;
    localparam logic [2:0] RULE_DEFAULT = 3'd7;

    // Queue between the parser and the rule engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Stream widths.
    localparam int S_TDATA_W = 8;
    localparam int CNT_W     = 64;
    localparam int M_FIELD_W = 4 + 4 * CNT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // One parsed frame handed from the parser to the rule engine.
    typedef struct packed {
        logic [15:0]      ether_type;
        logic [3:0]       header_words;
        logic [7:0]       proto_num;
        logic [31:0]      source_addr;
        logic [15:0]      src_port;
        logic [15:0]      dst_port;
        logic [OFF_W-1:0] frame_len;
    } ipf_rec_t;

    // Saturating 64-bit accumulate.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input logic [CNT_W-1:0] v);
        logic [CNT_W:0] s;
        s = {1'b0, c} + {1'b0, v};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/ipv4_packet_rule_filter_top.sv */
// Top level of the IPv4 rule filter: parser, record queue and rule engine.
//
// Usage: Ethernet frames enter on the s_ stream one byte per transfer,
// starting at the destination MAC address, with s_tlast on the final byte.
// For every frame one result transfer leaves on the m_ stream carrying the
// verdict, the matched rule and the four saturating statistics counters as
// they stand after that frame is counted. Nothing is emitted between frames.
// Throughput is one byte per cycle while the record queue is not full; the
// parser has no per-frame overhead. The edge that takes the last byte also
// writes the record queue; the result then passes through the classify
// register and the output register, in that order.
// When the receiver stalls, results wait in the output register, classify
// register and a four-entry record queue; s_tready drops only when that
// queue is full. Configuration writes on cfg_we take effect at the next
// edge and should only be issued while no frame is in flight.
// Reset (aresetn low, synchronous) clears the counters and the capture state
// and restores the default rule addresses.
`default_nettype none

module ipv4_packet_rule_filter_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [ipf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ipf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [7:0] pkt_byte
    input  wire logic [ipf_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] verdict, [3:1] rule_hit, [67:4] accepted_packets,
    // [131:68] dropped_packets, [195:132] accepted_bytes,
    // [259:196] dropped_bytes, [263:260] zero
    output logic [ipf_pkg::M_TDATA_W-1:0]         m_tdata
);
    import ipf_pkg::*;

    ipf_rec_t push_rec, pop_rec;
    logic     push_valid, q_full, pop_valid, pop_ready;

    ipf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .rec_valid (push_valid),
        .rec       (push_rec)
    );

    ipf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_rec    (push_rec),
        .full      (q_full),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_rec   (pop_rec)
    );

    ipf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_rec     (pop_rec),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

/* rtl/ipf_front.sv */
// Byte parser: captures header fields and emits one record per frame.
`default_nettype none

module ipf_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  q_full,
    output logic                       rec_valid,
    output ipf_pkg::ipf_rec_t          rec
);
    import ipf_pkg::*;

    logic [OFF_W-1:0] off_reg, len_next;
    logic [15:0]      etype_reg, etype_next;
    logic [3:0]       hw_reg, hw_next;
    logic [7:0]       proto_reg, proto_next;
    logic [31:0]      src_reg, src_next;
    logic [15:0]      sport_reg, sport_next;
    logic [15:0]      dport_reg, dport_next;
    logic [OFF_W-1:0] l4_off;
    logic             accept;

    // A byte is taken whenever the queue can hold a record.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Field capture for the byte at the current offset.
    always_comb begin
        etype_next = etype_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        if (off_reg == OFF_W'(OFF_ETYPE_HI)) etype_next[15:8] = s_tdata;
        if (off_reg == OFF_W'(OFF_ETYPE_LO)) etype_next[7:0]  = s_tdata;
        hw_next = (off_reg == OFF_W'(OFF_IHL)) ? s_tdata[3:0] : hw_reg;
        if (off_reg == OFF_W'(OFF_PROTO)) proto_next = s_tdata;
        if (off_reg == OFF_W'(OFF_SRC0)) src_next[31:24] = s_tdata;
        if (off_reg == OFF_W'(OFF_SRC1)) src_next[23:16] = s_tdata;
        if (off_reg == OFF_W'(OFF_SRC2)) src_next[15:8]  = s_tdata;
        if (off_reg == OFF_W'(OFF_SRC3)) src_next[7:0]   = s_tdata;
        // The L4 offset follows the header length, including one taken this byte.
        l4_off = OFF_W'(L4_BASE) + OFF_W'({hw_next, 2'b00});
        if (off_reg == l4_off)             sport_next[15:8] = s_tdata;
        if (off_reg == l4_off + OFF_W'(1)) sport_next[7:0]  = s_tdata;
        if (off_reg == l4_off + OFF_W'(2)) dport_next[15:8] = s_tdata;
        if (off_reg == l4_off + OFF_W'(3)) dport_next[7:0]  = s_tdata;
        // The offset stops at the maximum frame length.
        len_next = (off_reg < OFF_W'(MAX_FRAME_LEN)) ? off_reg + OFF_W'(1) : off_reg;
    end

    // Capture registers, cleared at the end of each frame.
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            off_reg   <= '0;
            etype_reg <= '0;
            hw_reg    <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
        end else if (accept) begin
            off_reg   <= len_next;
            etype_reg <= etype_next;
            hw_reg    <= hw_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
        end
    end

    // Record for the rule engine, pushed on the last byte.
    assign rec_valid        = accept && s_tlast;
    assign rec.ether_type   = etype_next;
    assign rec.header_words = hw_next;
    assign rec.proto_num    = proto_next;
    assign rec.source_addr  = src_next;
    assign rec.src_port     = sport_next;
    assign rec.dst_port     = dport_next;
    assign rec.frame_len    = len_next;

endmodule

`default_nettype wire

/* rtl/ipf_queue.sv */
// Small record queue between the parser and the rule engine.
`default_nettype none

module ipf_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire ipf_pkg::ipf_rec_t in_rec,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ipf_pkg::ipf_rec_t      out_rec
);
    import ipf_pkg::*;

    ipf_rec_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                push, pop;

    assign full      = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_rec   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && !full;
    assign pop       = out_valid && out_ready;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            if (push && !pop)      count_reg <= count_reg + (QUEUE_AW + 1)'(1);
            else if (pop && !push) count_reg <= count_reg - (QUEUE_AW + 1)'(1);
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_rec;
    end

endmodule

`default_nettype wire

/* rtl/ipf_back.sv */
// Rule engine: classifies queued records, keeps statistics, drives results.
`default_nettype none

module ipf_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [ipf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ipf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              q_valid,
    output logic                                   q_ready,
    input  wire ipf_pkg::ipf_rec_t                 q_rec,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ipf_pkg::M_TDATA_W-1:0]          m_tdata
);
    import ipf_pkg::*;

    logic [31:0]      bastion_reg;
    logic [23:0]      blocked_reg;
    logic [7:0]       admin_reg;

    logic [6:0]       l4;
    logic             tcp_ok, udp_ok, ssh, web, dns;
    logic [2:0]       rule_next;
    logic             drop_next;

    logic             s1_valid_reg;
    logic [2:0]       s1_rule_reg;
    logic             s1_drop_reg;
    logic [OFF_W-1:0] s1_len_reg;

    logic             m_valid_reg;
    logic [2:0]       m_rule_reg;
    logic             m_drop_reg;
    logic [CNT_W-1:0] acc_pkts_reg, drop_pkts_reg, acc_bytes_reg, drop_bytes_reg;
    logic [CNT_W-1:0] len_ext;
    logic             s2_load;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bastion_reg <= BASTION_RESET;
            blocked_reg <= BLOCKED_RESET;
            admin_reg   <= ADMIN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BASTION: bastion_reg <= cfg_wdata[31:0];
                CFG_BLOCKED: blocked_reg <= cfg_wdata[23:0];
                CFG_ADMIN:   admin_reg   <= cfg_wdata[7:0];
                default:     ;
            endcase
        end
    end

    // Ordered rule chain, first match wins.
    always_comb begin
        l4     = 7'(L4_BASE) + {1'b0, q_rec.header_words, 2'b00};
        tcp_ok = (q_rec.proto_num == PROTO_TCP) &&
                 (OFF_W'(l4) + OFF_W'(TCP_HDR_LEN) <= q_rec.frame_len);
        udp_ok = (q_rec.proto_num == PROTO_UDP) &&
                 (OFF_W'(l4) + OFF_W'(UDP_HDR_LEN) <= q_rec.frame_len);
        ssh    = tcp_ok && (q_rec.dst_port == PORT_SSH);
        web    = (q_rec.dst_port == PORT_HTTP) || (q_rec.dst_port == PORT_HTTPS) ||
                 (q_rec.dst_port == PORT_IPERF) || (q_rec.src_port == PORT_HTTP) ||
                 (q_rec.src_port == PORT_HTTPS) || (q_rec.src_port == PORT_IPERF);
        dns    = (q_rec.dst_port == PORT_DNS) || (q_rec.dst_port == PORT_UDPT);
        if (q_rec.frame_len < OFF_W'(MIN_IP_LEN) || q_rec.ether_type != ETH_IPV4) begin
            rule_next = RULE_NON_IP;
        end else if (q_rec.source_addr == bastion_reg && ssh) begin
            rule_next = RULE_BASTION;
        end else if (q_rec.source_addr[31:8] == blocked_reg) begin
            rule_next = RULE_SUBNET;
        end else if (ssh && q_rec.source_addr[31:24] == admin_reg) begin
            rule_next = RULE_ADMIN;
        end else if (tcp_ok && web) begin
            rule_next = RULE_TCP;
        end else if (udp_ok && dns) begin
            rule_next = RULE_UDP;
        end else if (q_rec.proto_num == PROTO_ICMP) begin
            rule_next = RULE_ICMP;
        end else begin
            rule_next = RULE_DEFAULT;
        end
        drop_next = rule_next inside {RULE_SUBNET, RULE_ADMIN, RULE_DEFAULT};
    end

    // Pipeline handshake: classify stage feeds the output register.
    assign s2_load = !m_valid_reg || m_tready;
    assign q_ready = !s1_valid_reg || s2_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (q_valid && q_ready) begin
            s1_valid_reg <= 1'b1;
        end else if (s2_load) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            s1_rule_reg <= rule_next;
            s1_drop_reg <= drop_next;
            s1_len_reg  <= q_rec.frame_len;
        end
    end

    // Statistics and output register.
    assign len_ext = CNT_W'(s1_len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            acc_pkts_reg   <= '0;
            drop_pkts_reg  <= '0;
            acc_bytes_reg  <= '0;
            drop_bytes_reg <= '0;
        end else if (s2_load) begin
            m_valid_reg <= s1_valid_reg;
            if (s1_valid_reg) begin
                if (s1_drop_reg) begin
                    drop_pkts_reg  <= sat_add(drop_pkts_reg, CNT_W'(1));
                    drop_bytes_reg <= sat_add(drop_bytes_reg, len_ext);
                end else begin
                    acc_pkts_reg   <= sat_add(acc_pkts_reg, CNT_W'(1));
                    acc_bytes_reg  <= sat_add(acc_bytes_reg, len_ext);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_load && s1_valid_reg) begin
            m_rule_reg <= s1_rule_reg;
            m_drop_reg <= s1_drop_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - M_FIELD_W)'(0), drop_bytes_reg, acc_bytes_reg,
                       drop_pkts_reg, acc_pkts_reg, m_rule_reg, m_drop_reg};

endmodule

`default_nettype wire
